[rtl/core/cpf_pkg.sv]
// Coulomb pair force: shared widths, register codes and payload/tag structs.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpf_pkg;

   localparam int POS_W      = 32;
   localparam int CHG_W      = 24;
   localparam int FRC_W      = 48;
   localparam int SCALE_W    = 32;
   localparam int LINK_W     = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam int R_W      = POS_W + 1;   // exact coordinate difference
   localparam int ABS_Q_W  = CHG_W;
   localparam int PQ_W     = 47;          // |q1|*|q2| <= 2^46
   localparam int PKL_W    = 64;
   localparam int PKH_W    = 47;
   localparam int PK_W     = 78;          // pq * scale
   localparam int LEN_W    = 6;
   localparam int SH_W     = 7;
   localparam int AN_W     = 20;
   localparam int SQ_W     = 2 * AN_W;
   localparam int D2_W     = 42;
   localparam int ROOT_W   = 21;
   localparam int G_W      = 25;
   localparam int H_W      = 44;
   localparam int G_SHIFT  = 43;
   localparam int H_SHIFT  = 38;
   localparam int NORM_LEN = 20;
   localparam int SH_OFS   = 25;          // 65 - 2 * NORM_LEN
   localparam int PK_CH_W  = 26;
   localparam int H_CH_W   = 22;
   localparam int PP_W     = PK_CH_W + H_CH_W;
   localparam int PS_W     = PP_W + H_CH_W;
   localparam int PROD_W   = 122;
   localparam int MAG_W    = 47;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK  = 8'd1;

   localparam logic [SCALE_W-1:0] SCALE_RST = 32'd35567;
   localparam logic [LINK_W-1:0]  LINK_RST  = 2'd3;
   localparam logic [LINK_W-1:0]  LINK_EXCL = 2'd0;

   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   typedef struct packed {
      logic signed [POS_W-1:0] qm_x;
      logic signed [POS_W-1:0] qm_y;
      logic signed [POS_W-1:0] qm_z;
      logic signed [POS_W-1:0] mm_x;
      logic signed [POS_W-1:0] mm_y;
      logic signed [POS_W-1:0] mm_z;
      logic signed [CHG_W-1:0] qm_chg;
      logic signed [CHG_W-1:0] mm_charge;
      logic                    qm_linked;
   } req_type;

   typedef struct packed {
      logic signed [FRC_W-1:0] force_x;
      logic signed [FRC_W-1:0] force_y;
      logic signed [FRC_W-1:0] force_z;
      logic                    zero_distance;
   } rsp_type;

   typedef struct packed {
      logic            zero;
      logic            supp;
      logic            qneg;
      logic [SH_W-1:0] sh;
      logic [PK_W-1:0] pk;
   } cmn_type;

   typedef struct packed {
      cmn_type                cmn;
      logic [2:0]             neg;
      logic [2:0][AN_W-1:0]   an;
      logic [D2_W-1:0]        d2;
   } sq_tag_type;

   typedef struct packed {
      cmn_type             cmn;
      logic                neg;
      logic [ROOT_W-1:0]   droot;
   } gtag_type;

   typedef struct packed {
      cmn_type cmn;
      logic    neg;
   } htag_type;

endpackage

`default_nettype wire

[rtl/core/cpf_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. Caller guarantees num < den * 2^QW. Uses cpf_pkg.
`default_nettype none

module cpf_div_pipe #(
   parameter int NW = 63,
   parameter int DW = 42,
   parameter int QW = 25,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [TW-1:0] out_tag
);
   import cpf_pkg::*;

   localparam int W  = DW + QW;
   localparam int W1 = W + 1;

   logic          vld_ff [QW];
   logic [W-1:0]  rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [TW-1:0] tag_ff [QW];

   genvar k;
   for (k = 0; k < QW; k++) begin : g_stage
      logic          src_vld;
      logic [W-1:0]  src_rem;
      logic [DW-1:0] src_den;
      logic [QW-1:0] src_quo;
      logic [TW-1:0] src_tag;
      logic [W:0]    diff;
      logic [W-1:0]  rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_rem = W'(in_num);
         assign src_den = in_den;
         assign src_quo = '0;
         assign src_tag = in_tag;
      end else begin : g_next
         assign src_vld = vld_ff[k-1];
         assign src_rem = rem_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_quo = quo_ff[k-1];
         assign src_tag = tag_ff[k-1];
      end

      always_comb begin
         diff   = {1'b0, src_rem} - (W1'(src_den) << (QW - 1 - k));
         rem_in = src_rem;
         quo_in = src_quo;
         if (!diff[W]) begin
            rem_in            = diff[W-1:0];
            quo_in[QW-1-k]    = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= src_den;
         quo_ff[k] <= quo_in;
         tag_ff[k] <= src_tag;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

`default_nettype wire

[rtl/core/cpf_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage, tag alongside.
// Requires VW <= 2*RW. Uses cpf_pkg.
`default_nettype none

module cpf_sqrt_pipe #(
   parameter int VW = 42,
   parameter int RW = 21,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [VW-1:0] in_val,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [RW-1:0] out_root,
   output logic [TW-1:0] out_tag
);
   import cpf_pkg::*;

   localparam int V1 = VW + 1;

   logic          vld_ff  [RW];
   logic [VW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [TW-1:0] tag_ff  [RW];

   genvar k;
   for (k = 0; k < RW; k++) begin : g_stage
      logic          src_vld;
      logic [VW-1:0] src_rem;
      logic [RW-1:0] src_root;
      logic [TW-1:0] src_tag;
      logic [VW:0]   trial;
      logic [VW:0]   diff;
      logic [VW-1:0] rem_in;
      logic [RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_rem  = in_val;
         assign src_root = '0;
         assign src_tag  = in_tag;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_tag  = tag_ff[k-1];
      end

      // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b); root has no bits at or below b
      always_comb begin
         trial   = (V1'(src_root) << (RW - k)) | (V1'(1) << (2 * (RW - 1 - k)));
         diff    = {1'b0, src_rem} - trial;
         rem_in  = src_rem;
         root_in = src_root;
         if (!diff[VW]) begin
            rem_in             = diff[VW-1:0];
            root_in[RW-1-k]    = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         tag_ff[k]  <= src_tag;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

`default_nettype wire

[rtl/core/coulomb_pair_force.sv]
// Coulomb pair force, top level. One quantum/classical atom pair per request,
// one force vector per request. Uses cpf_pkg, cpf_sqrt_pipe, cpf_div_pipe.
//
// Request channel: a pair is taken at a rising edge with start high and busy
// low. busy is always low: the block is a fully pipelined datapath and takes
// a new request every cycle.
// Result channel: rsp_valid is high for one cycle with rsp_data; the
// receiver cannot hold results off, and none is needed since nothing stalls.
// The pipeline depth is set by the bit-per-stage units: a 21-stage
// square root, a 25-stage divider for r/d^2 and a 44-stage divider for the
// final /d, plus 8 front and 5 back stages (multiplies split 26x22).
// Throughput: one request per cycle, results in request order.
// CSR channel: csr_ready is always high; index 0 is the Coulomb scale, index
// 1 the link mode, other indexes are ignored. Write only while no request
// is in flight.
// Reset clears the pipeline valid bits and restores the CSR reset values.
`default_nettype none

module coulomb_pair_force (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  cpf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output cpf_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cpf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cpf_pkg::*;

   // ---------------- configuration ----------------
   logic [SCALE_W-1:0] scale_ff;
   logic [LINK_W-1:0]  link_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RST;
         link_ff  <= LINK_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCALE: scale_ff <= csr_data[SCALE_W-1:0];
            CSR_LINK:  link_ff  <= csr_data[LINK_W-1:0];
            default:   ;
         endcase
      end
   end

   // ---------------- front pipeline ----------------
   logic [7:0] fv_ff;
   logic       accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         fv_ff <= {fv_ff[6:0], accept};
      end
   end

   // F0: request register
   req_type f0_req_ff;

   // F1: differences, charge magnitudes
   logic [2:0][R_W-1:0]  f1_r_ff;
   logic [ABS_Q_W-1:0]   f1_qa1_ff, f1_qa2_ff;
   logic                 f1_qneg_ff, f1_supp_ff;

   // F2: |r|, pq
   logic [2:0][R_W-1:0]  f2_a_ff;
   logic [2:0]           f2_neg_ff;
   logic [PQ_W-1:0]      f2_pq_ff;
   logic                 f2_qneg_ff, f2_supp_ff;

   // F3: max, pq*scale partials
   logic [2:0][R_W-1:0]  f3_a_ff;
   logic [2:0]           f3_neg_ff;
   logic [R_W-1:0]       f3_m_ff;
   logic [PKL_W-1:0]     f3_pkl_ff;
   logic [PKH_W-1:0]     f3_pkh_ff;
   logic                 f3_qneg_ff, f3_supp_ff;

   // F4: bit length, pq*scale
   logic [2:0][R_W-1:0]  f4_a_ff;
   logic [2:0]           f4_neg_ff;
   logic [LEN_W-1:0]     f4_len_ff;
   logic [PK_W-1:0]      f4_pk_ff;
   logic                 f4_zero_ff, f4_qneg_ff, f4_supp_ff;

   // F5: normalized components
   logic [2:0][AN_W-1:0] f5_an_ff;
   logic [2:0]           f5_neg_ff;
   cmn_type              f5_cmn_ff;

   // F6: squares
   logic [2:0][SQ_W-1:0] f6_sq_ff;
   logic [2:0][AN_W-1:0] f6_an_ff;
   logic [2:0]           f6_neg_ff;
   cmn_type              f6_cmn_ff;

   // F7: |r|^2
   sq_tag_type           f7_tag_ff;

   logic [2:0][POS_W-1:0] qm_pos, mm_pos;
   logic [R_W-1:0]        m_in;
   logic [LEN_W-1:0]      len_in;
   logic [2:0][AN_W-1:0]  an_in;

   assign qm_pos = {f0_req_ff.qm_z, f0_req_ff.qm_y, f0_req_ff.qm_x};
   assign mm_pos = {f0_req_ff.mm_z, f0_req_ff.mm_y, f0_req_ff.mm_x};

   always_comb begin
      m_in = f2_a_ff[0];
      if (f2_a_ff[1] > m_in) begin
         m_in = f2_a_ff[1];
      end
      if (f2_a_ff[2] > m_in) begin
         m_in = f2_a_ff[2];
      end
   end

   always_comb begin
      len_in = '0;
      for (int i = 0; i < R_W; i++) begin
         if (f3_m_ff[i]) begin
            len_in = LEN_W'(i + 1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (f4_len_ff > LEN_W'(NORM_LEN)) begin
            an_in[i] = AN_W'(f4_a_ff[i] >> (f4_len_ff - LEN_W'(NORM_LEN)));
         end else begin
            an_in[i] = AN_W'(f4_a_ff[i] << (LEN_W'(NORM_LEN) - f4_len_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f0_req_ff <= req_data;
      end

      for (int i = 0; i < 3; i++) begin
         f1_r_ff[i] <= {qm_pos[i][POS_W-1], qm_pos[i]} - {mm_pos[i][POS_W-1], mm_pos[i]};
      end
      f1_qa1_ff  <= f0_req_ff.qm_chg[CHG_W-1] ? ABS_Q_W'(-f0_req_ff.qm_chg)
                                              : ABS_Q_W'(f0_req_ff.qm_chg);
      f1_qa2_ff  <= f0_req_ff.mm_charge[CHG_W-1] ? ABS_Q_W'(-f0_req_ff.mm_charge)
                                                 : ABS_Q_W'(f0_req_ff.mm_charge);
      f1_qneg_ff <= f0_req_ff.qm_chg[CHG_W-1] ^ f0_req_ff.mm_charge[CHG_W-1];
      f1_supp_ff <= f0_req_ff.qm_linked && (link_ff == LINK_EXCL);

      for (int i = 0; i < 3; i++) begin
         f2_neg_ff[i] <= f1_r_ff[i][R_W-1];
         f2_a_ff[i]   <= f1_r_ff[i][R_W-1] ? -f1_r_ff[i] : f1_r_ff[i];
      end
      f2_pq_ff   <= PQ_W'(f1_qa1_ff * f1_qa2_ff);
      f2_qneg_ff <= f1_qneg_ff;
      f2_supp_ff <= f1_supp_ff;

      f3_a_ff    <= f2_a_ff;
      f3_neg_ff  <= f2_neg_ff;
      f3_m_ff    <= m_in;
      f3_pkl_ff  <= PKL_W'(f2_pq_ff[31:0] * scale_ff);
      f3_pkh_ff  <= PKH_W'(f2_pq_ff[PQ_W-1:32] * scale_ff);
      f3_qneg_ff <= f2_qneg_ff;
      f3_supp_ff <= f2_supp_ff;

      f4_a_ff    <= f3_a_ff;
      f4_neg_ff  <= f3_neg_ff;
      f4_len_ff  <= len_in;
      f4_pk_ff   <= PK_W'(f3_pkl_ff) + (PK_W'(f3_pkh_ff) << 32);
      f4_zero_ff <= (f3_m_ff == '0);
      f4_qneg_ff <= f3_qneg_ff;
      f4_supp_ff <= f3_supp_ff;

      f5_an_ff       <= an_in;
      f5_neg_ff      <= f4_neg_ff;
      f5_cmn_ff.zero <= f4_zero_ff;
      f5_cmn_ff.supp <= f4_supp_ff;
      f5_cmn_ff.qneg <= f4_qneg_ff;
      f5_cmn_ff.sh   <= SH_W'(SH_OFS) + {f4_len_ff, 1'b0};
      f5_cmn_ff.pk   <= f4_pk_ff;

      for (int i = 0; i < 3; i++) begin
         f6_sq_ff[i] <= f5_an_ff[i] * f5_an_ff[i];
      end
      f6_an_ff  <= f5_an_ff;
      f6_neg_ff <= f5_neg_ff;
      f6_cmn_ff <= f5_cmn_ff;

      f7_tag_ff.d2  <= D2_W'(f6_sq_ff[0]) + D2_W'(f6_sq_ff[1]) + D2_W'(f6_sq_ff[2]);
      f7_tag_ff.an  <= f6_an_ff;
      f7_tag_ff.neg <= f6_neg_ff;
      f7_tag_ff.cmn <= f6_cmn_ff;
   end

   // ---------------- square root ----------------
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   sq_tag_type        sq_tag;

   cpf_sqrt_pipe #(
      .VW (D2_W),
      .RW (ROOT_W),
      .TW ($bits(sq_tag_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fv_ff[7]),
      .in_val    (f7_tag_ff.d2),
      .in_tag    (f7_tag_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // ---------------- per-axis lanes ----------------
   logic            h_vld [3];
   logic [H_W-1:0]  h_quo [3];
   htag_type        h_tag [3];

   logic [2:0][1:0][PP_W-1:0] b0_pp_ff  [3];
   htag_type                  b0_tag_ff [3];
   logic [2:0][PS_W-1:0]      b1_ps_ff  [3];
   htag_type                  b1_tag_ff [3];
   logic [PROD_W-1:0]         b2_prod_ff[3];
   htag_type                  b2_tag_ff [3];
   logic [PROD_W-1:0]         b3_shr_ff [3];
   htag_type                  b3_tag_ff [3];
   logic [FRC_W-1:0]          frc_ff    [3];

   genvar ax;
   for (ax = 0; ax < 3; ax++) begin : g_lane
      logic           g_vld;
      logic [G_W-1:0] g_quo;
      gtag_type       g_in_tag, g_tag;
      htag_type       h_in_tag;
      logic [MAG_W-1:0] mag;

      assign g_in_tag.cmn   = sq_tag.cmn;
      assign g_in_tag.neg   = sq_tag.neg[ax];
      assign g_in_tag.droot = sq_root;

      cpf_div_pipe #(
         .NW (AN_W + G_SHIFT),
         .DW (D2_W),
         .QW (G_W),
         .TW ($bits(gtag_type))
      ) u_gdiv (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_vld),
         .in_num    ({sq_tag.an[ax], {G_SHIFT{1'b0}}}),
         .in_den    (sq_tag.d2),
         .in_tag    (g_in_tag),
         .out_valid (g_vld),
         .out_quo   (g_quo),
         .out_tag   (g_tag)
      );

      assign h_in_tag.cmn = g_tag.cmn;
      assign h_in_tag.neg = g_tag.neg;

      cpf_div_pipe #(
         .NW (G_W + H_SHIFT),
         .DW (ROOT_W),
         .QW (H_W),
         .TW ($bits(htag_type))
      ) u_hdiv (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (g_vld),
         .in_num    ({g_quo, {H_SHIFT{1'b0}}}),
         .in_den    (g_tag.droot),
         .in_tag    (h_in_tag),
         .out_valid (h_vld[ax]),
         .out_quo   (h_quo[ax]),
         .out_tag   (h_tag[ax])
      );

      // saturate the shifted product to 47 bits of magnitude
      assign mag = (b3_shr_ff[ax][PROD_W-1:MAG_W] != '0) ? MAG_MAX
                                                        : b3_shr_ff[ax][MAG_W-1:0];

      always_ff @(posedge clock) begin
         for (int c = 0; c < 3; c++) begin
            for (int e = 0; e < 2; e++) begin
               b0_pp_ff[ax][c][e] <= h_tag[ax].cmn.pk[c*PK_CH_W +: PK_CH_W]
                                     * h_quo[ax][e*H_CH_W +: H_CH_W];
            end
         end
         b0_tag_ff[ax] <= h_tag[ax];

         for (int c = 0; c < 3; c++) begin
            b1_ps_ff[ax][c] <= PS_W'(b0_pp_ff[ax][c][0])
                               + (PS_W'(b0_pp_ff[ax][c][1]) << H_CH_W);
         end
         b1_tag_ff[ax] <= b0_tag_ff[ax];

         b2_prod_ff[ax] <= PROD_W'(b1_ps_ff[ax][0])
                           + (PROD_W'(b1_ps_ff[ax][1]) << PK_CH_W)
                           + (PROD_W'(b1_ps_ff[ax][2]) << (2 * PK_CH_W));
         b2_tag_ff[ax]  <= b1_tag_ff[ax];

         b3_shr_ff[ax] <= b2_prod_ff[ax] >> b2_tag_ff[ax].cmn.sh;
         b3_tag_ff[ax] <= b2_tag_ff[ax];

         if (b3_tag_ff[ax].cmn.zero || b3_tag_ff[ax].cmn.supp) begin
            frc_ff[ax] <= '0;
         end else if (b3_tag_ff[ax].cmn.qneg ^ b3_tag_ff[ax].neg) begin
            frc_ff[ax] <= -FRC_W'(mag);
         end else begin
            frc_ff[ax] <= FRC_W'(mag);
         end
      end
   end

   // ---------------- back-end valid and output ----------------
   logic [4:0] bv_ff;
   logic       zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else begin
         bv_ff <= {bv_ff[3:0], h_vld[0] && h_vld[1] && h_vld[2]};
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= b3_tag_ff[0].cmn.zero;
   end

   assign rsp_valid              = bv_ff[4];
   assign rsp_data.force_x       = frc_ff[0];
   assign rsp_data.force_y       = frc_ff[1];
   assign rsp_data.force_z       = frc_ff[2];
   assign rsp_data.zero_distance = zero_ff;

endmodule

`default_nettype wire

[sim/tb_coulomb_pair_force.sv]
// Testbench for coulomb_pair_force: directed and random atom pairs, with CSR phases.
// Expected forces come from an in-bench integer predictor; depends on cpf_pkg and the RTL.
`timescale 1ns / 1ps

class force_board;
   cpf_pkg::rsp_type pending[$];
   int errors = 0;

   static function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // note an accepted request; predicts with the register values in force
   function void note(cpf_pkg::req_type q, logic [31:0] scale, logic [1:0] mode);
      cpf_pkg::rsp_type e;
      longint dif[3];
      logic [63:0] a[3];
      logic neg[3];
      logic [63:0] m, d2, dd, pq, g, h, q1, q2;
      logic [127:0] prod;
      logic [127:0] v;
      logic [47:0] mag, fv[3];
      logic qneg;
      int len, s, sh;
      dif[0] = longint'(q.qm_x) - longint'(q.mm_x);
      dif[1] = longint'(q.qm_y) - longint'(q.mm_y);
      dif[2] = longint'(q.qm_z) - longint'(q.mm_z);
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = dif[i] < 0;
         a[i] = neg[i] ? 64'(-dif[i]) : 64'(dif[i]);
         if (a[i] > m) m = a[i];
         fv[i] = '0;
      end
      q1 = q.qm_chg < 0 ? 64'(-longint'(q.qm_chg)) : 64'(longint'(q.qm_chg));
      q2 = q.mm_charge < 0 ? 64'(-longint'(q.mm_charge)) : 64'(longint'(q.mm_charge));
      qneg = (q.qm_chg < 0) != (q.mm_charge < 0);
      e.zero_distance = (m == 0);
      if (m != 0 && !(q.qm_linked && mode == cpf_pkg::LINK_EXCL)) begin
         len = 0;
         while (len < 64 && (m >> len) != 0) len++;
         s = len - 20;
         d2 = 0;
         for (int i = 0; i < 3; i++) begin
            if (s > 0) a[i] = a[i] >> s;
            else if (s < 0) a[i] = a[i] << (-s);
            d2 += a[i] * a[i];
         end
         dd = root64(d2);
         pq = q1 * q2;
         sh = 65 + 2 * s;
         for (int i = 0; i < 3; i++) begin
            g = (a[i] << 43) / d2;
            h = (g << 38) / dd;
            prod = 128'(pq) * 128'(h) * 128'(scale);
            v = prod >> sh;
            mag = (v > 128'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : v[47:0];
            fv[i] = (mag != 0 && qneg != neg[i]) ? -mag : mag;
         end
      end
      e.force_x = fv[0];
      e.force_y = fv[1];
      e.force_z = fv[2];
      pending.push_back(e);
   endfunction

   function void check(cpf_pkg::rsp_type r);
      cpf_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected result %h", r);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (r.force_x !== e.force_x) begin
         $error("force_x exp %h got %h", e.force_x, r.force_x); errors++;
      end
      if (r.force_y !== e.force_y) begin
         $error("force_y exp %h got %h", e.force_y, r.force_y); errors++;
      end
      if (r.force_z !== e.force_z) begin
         $error("force_z exp %h got %h", e.force_z, r.force_z); errors++;
      end
      if (r.zero_distance !== e.zero_distance) begin
         $error("zero_distance exp %b got %b", e.zero_distance, r.zero_distance);
         errors++;
      end
   endfunction
endclass

module tb_coulomb_pair_force;
   import cpf_pkg::*;

   localparam int LATENCY = 103;
   localparam int STALL_LIMIT = 5000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [31:0] scale_reg = SCALE_RST;
   logic [1:0] link_reg = LINK_RST;
   int idle_pct = 0;
   int quiet = 0;
   force_board board = new();

   coulomb_pair_force dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check(rsp_data);
   end

   // watchdog: cycles with no request or result moving
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send(req_type q);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_data <= q;
      do @(posedge clock); while (busy);
      board.note(q, scale_reg, link_reg);
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_SCALE) scale_reg = val;
      else if (idx == CSR_LINK) link_reg = val[1:0];
      @(posedge clock);
   endtask

   function automatic req_type rand_pair();
      req_type q;
      int k;
      q = req_type'($bits(req_type)'({$urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom}));
      q.qm_linked = 1'($urandom_range(1));
      case ($urandom_range(9))
         0, 1: ; // arbitrary positions
         9: begin
            q.mm_x = q.qm_x; q.mm_y = q.qm_y; q.mm_z = q.qm_z;
         end
         default: begin
            k = $urandom_range(31);
            q.mm_x = q.qm_x + ($signed($urandom) >>> k);
            q.mm_y = q.qm_y + ($signed($urandom) >>> k);
            q.mm_z = q.qm_z + ($signed($urandom) >>> k);
            if ($urandom_range(3) == 0) q.mm_y = q.qm_y;
         end
      endcase
      return q;
   endfunction

   function automatic req_type pair(int qx, int qy, int qz, int mx, int my, int mz,
                                    int c1, int c2, bit lk);
      req_type q;
      q.qm_x = qx; q.qm_y = qy; q.qm_z = qz;
      q.mm_x = mx; q.mm_y = my; q.mm_z = mz;
      q.qm_chg = CHG_W'(c1); q.mm_charge = CHG_W'(c2); q.qm_linked = lk;
      return q;
   endfunction

   task automatic directed();
      int mx, mn;
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      send(pair(0, 0, 0, 0, 0, 0, 65536, 65536, 0));                 // coincident
      send(pair(5, -7, 9, 5, -7, 9, 65536, -65536, 1));
      send(pair(1 << 20, 0, 0, 0, 0, 0, 65536, 65536, 0));
      send(pair(1 << 20, 0, 0, 0, 0, 0, 65536, 65536, 1));           // linked
      send(pair(1, 0, 0, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 0));       // saturates
      send(pair(0, 1, 0, 0, 0, 0, 24'h800000, 24'h7FFFFF, 0));
      send(pair(0, 0, -1, 0, 0, 0, 24'h800000, 24'h800000, 0));
      send(pair(mx, mx, mx, mn, mn, mn, 24'h7FFFFF, 24'h800000, 0)); // widest r
      send(pair(mn, mn, mn, mx, mx, mx, 24'h800000, 24'h800000, 1));
      send(pair(mx, 0, mn, mn, 0, mx, 1, 1, 0));
      send(pair(3 << 19, 4 << 19, 0, 0, 0, 0, -1, 1, 0));
      send(pair(1000, -2000, 3000, -1000, 2000, -3000, 0, 65536, 0)); // zero charge
      send(pair(123456, 654321, -111111, 0, 0, 0, 65536, 0, 1));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed();
      drain();
      csr_write(CSR_LINK, 0);
      directed();
      drain();
      csr_write(CSR_SCALE, 0);
      csr_write(CSR_LINK, 1);
      directed();
      drain();
      csr_write(CSR_SCALE, 32'hFFFF_FFFF);
      csr_write(CSR_LINK, 2);
      csr_write(8'd7, 32'h1234);                  // unmapped index, ignored
      for (int i = 0; i < 20; i++) send(rand_pair());
      drain();
      csr_write(CSR_SCALE, SCALE_RST);
      csr_write(CSR_LINK, 3);
      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 3)
            0: idle_pct = 0;
            1: idle_pct = 86;
            default: idle_pct = 13;
         endcase
         if (ph == 3) csr_write(CSR_LINK, 0);
         if (ph == 4) csr_write(CSR_SCALE, $urandom);
         if (ph == 5) csr_write(CSR_LINK, $urandom_range(3));
         for (int i = 0; i < 80; i++) begin
            send(rand_pair());
            if (i == 40) begin
               start <= 0;
               while (board.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/core/cpf_pkg.sv
rtl/core/cpf_div_pipe.sv
rtl/core/cpf_sqrt_pipe.sv
rtl/core/coulomb_pair_force.sv
sim/tb_coulomb_pair_force.sv
